[rtl/per_source_packet_limiter_top_assert.svh]
// Assertion macros for the per-source packet limiter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PER_SOURCE_PACKET_LIMITER_TOP_ASSERT_SVH
`define PER_SOURCE_PACKET_LIMITER_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define PSL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PSL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/psl_pkg.sv]
// Shared constants and types for the per-source packet limiter.
// No dependencies.
package psl_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int USED_W      = $clog2(MAX_SOURCES + 1);
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 8;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

    localparam logic [1:0] OUT_KNOWN    = 2'd0;
    localparam logic [1:0] OUT_INSERTED = 2'd1;
    localparam logic [1:0] OUT_BLOCKED  = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

[rtl/per_source_packet_limiter_top.sv]
// Per-source packet count limiter: sequential table scan with one comparator.
// The scan compares one entry at a time from entry 0 (first hit ends the scan, at most
// the filled entries); a new input is taken only back in idle, after the result is
// registered. A result still waiting at the output stalls the final step.
// Reset clears the fill count and the output valid flag and sets the limit to 3;
// table contents stay undefined until written, and there is no clearing pass.
`include "per_source_packet_limiter_top_assert.svh"

module per_source_packet_limiter_top
    import psl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [COUNT_W-1:0]  cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADDR_W-1:0]   source_address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                pass_packet,
    output logic [1:0]          outcome
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] limit_reg;
    logic [USED_W-1:0]  entries_used_reg, entries_used_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               hit_reg, hit_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic               out_valid_reg, out_valid_next;
    logic               pass_reg, pass_next;
    logic [1:0]         outcome_reg, outcome_next;

    entry_t             table_mem [MAX_SOURCES];
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic               in_xfer;
    logic               out_free;
    logic               addr_match;
    logic               scan_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign pass_packet = pass_reg;
    assign outcome   = outcome_reg;

    // shared comparator on the registered read data
    assign addr_match = (rd_data_reg.addr == addr_reg);
    assign scan_last  = (USED_W'(rd_idx_reg) + USED_W'(1)) >= entries_used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        entries_used_next = entries_used_reg;
        addr_next         = addr_reg;
        rd_idx_next       = rd_idx_reg;
        hit_next          = hit_reg;
        hit_count_next    = hit_count_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        pass_next         = pass_reg;
        outcome_next      = outcome_reg;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = rd_idx_reg;
        wr_data.addr      = addr_reg;
        wr_data.count     = hit_count_reg + COUNT_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next   = source_address;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    state_next  = (entries_used_reg == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr = rd_idx_reg + IDX_W'(1);
                if (addr_match)
                begin
                    hit_next       = 1'b1;
                    hit_count_next = rd_data_reg.count;
                    state_next     = S_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (hit_reg)
                    begin
                        if (hit_count_reg >= limit_reg)
                        begin
                            pass_next    = 1'b0;
                            outcome_next = OUT_BLOCKED;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            pass_next    = 1'b1;
                            outcome_next = OUT_KNOWN;
                        end
                    end
                    else if (entries_used_reg < USED_W'(MAX_SOURCES))
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = entries_used_reg[IDX_W-1:0];
                        wr_data.count     = COUNT_W'(1);
                        entries_used_next = entries_used_reg + USED_W'(1);
                        pass_next         = 1'b1;
                        outcome_next      = OUT_INSERTED;
                    end
                    else
                    begin
                        pass_next    = 1'b1;
                        outcome_next = OUT_FULL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_reg        <= LIMIT_RESET;
            entries_used_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entries_used_reg <= entries_used_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        hit_reg       <= hit_next;
        hit_count_reg <= hit_count_next;
        pass_reg      <= pass_next;
        outcome_reg   <= outcome_next;
    end

    `PSL_ASSERT_ALWAYS(a_used_bound, entries_used_reg <= USED_W'(MAX_SOURCES),
        "entry count beyond table depth")
    `PSL_ASSERT_IMP(a_scan_filled, state_reg == S_SCAN,
        USED_W'(rd_idx_reg) < entries_used_reg, "scan reads an unfilled entry")
    `PSL_ASSERT_IMP(a_pass_code, out_valid_reg,
        pass_reg == (outcome_reg != OUT_BLOCKED), "pass flag disagrees with outcome")
    `PSL_ASSERT_NEXT(a_used_step, 1'b1,
        entries_used_reg == $past(entries_used_reg) ||
        entries_used_reg == USED_W'($past(entries_used_reg) + USED_W'(1)),
        "entry count moved by more than one")

endmodule
